// ===== hw/rtl/modular_exponentiation_unit_defines.svh =====
// Assertion macros for the modular exponentiation unit.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MEU_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("meu assertion failed");
`define MEU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("meu assertion failed");
`else
`define MEU_ASSERT(label, cond)
`define MEU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/meu_pkg.sv =====
package meu_pkg;

  localparam int EXP_BITS      = 32;
  localparam int MOD_BITS      = 16;
  localparam int BASE_BITS     = 32;
  localparam int RES_BITS      = MOD_BITS;
  localparam int PROD_BITS     = 2 * MOD_BITS;
  localparam int HI_STEPS      = MOD_BITS - MOD_BITS / 2;
  localparam int LO_STEPS      = MOD_BITS / 2;
  localparam int BASE_CHUNK    = 8;
  localparam int BASE_STAGES   = (BASE_BITS + BASE_CHUNK - 1) / BASE_CHUNK;
  localparam int BASE_PAD_BITS = BASE_STAGES * BASE_CHUNK;
  localparam int IN_DATA_BITS  = ((BASE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((RES_BITS + 7) / 8) * 8;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;

  localparam logic [EXP_BITS-1:0] EXP_RESET = EXP_BITS'(7);
  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(16459);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_EXPONENT = 1'b0,
    CFG_MODULUS  = 1'b1
  } cfg_idx_t;

  // accumulator and running power of one item
  typedef struct packed {
    logic [MOD_BITS-1:0] acc;
    logic [MOD_BITS-1:0] pw;
  } ap_t;

  // one restoring step: shift in one bit, subtract m if it fits (shifted value >= m)
  function automatic logic [MOD_BITS-1:0] rem_step(input logic [MOD_BITS-1:0] rem,
                                                   input logic                b,
                                                   input logic [MOD_BITS-1:0] m);
    logic [MOD_BITS:0] t;
    t = {rem, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[MOD_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/meu_base_reduce.sv =====
module meu_base_reduce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [meu_pkg::MOD_BITS-1:0]  m,
  input  logic                          in_valid,
  input  logic [meu_pkg::BASE_BITS-1:0] in_base,
  output logic                          out_valid,
  output logic [meu_pkg::MOD_BITS-1:0]  out_rem
);

  logic [meu_pkg::BASE_STAGES-1:0]   v_r;
  logic [meu_pkg::MOD_BITS-1:0]      rem_r [meu_pkg::BASE_STAGES];
  logic [meu_pkg::BASE_PAD_BITS-1:0] sh_r  [meu_pkg::BASE_STAGES];

  for (genvar s = 0; s < meu_pkg::BASE_STAGES; s++) begin : g_stage
    logic                              v_in;
    logic [meu_pkg::MOD_BITS-1:0]      rem_in;
    logic [meu_pkg::BASE_PAD_BITS-1:0] sh_in;
    logic [meu_pkg::MOD_BITS-1:0]      rem_nxt;
    logic [meu_pkg::BASE_PAD_BITS-1:0] sh_nxt;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign sh_in  = meu_pkg::BASE_PAD_BITS'(in_base);
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign rem_in = rem_r[s-1];
      assign sh_in  = sh_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      for (int k = 0; k < meu_pkg::BASE_CHUNK; k++) begin
        rem_nxt = meu_pkg::rem_step(rem_nxt, sh_in[meu_pkg::BASE_PAD_BITS-1-k], m);
      end
      sh_nxt = sh_in << meu_pkg::BASE_CHUNK;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        sh_r[s]  <= sh_nxt;
      end
    end
  end

  assign out_valid = v_r[meu_pkg::BASE_STAGES-1];
  assign out_rem   = rem_r[meu_pkg::BASE_STAGES-1];

endmodule

// ===== hw/rtl/meu_exp_step.sv =====
module meu_exp_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         ebit,
  input  logic [meu_pkg::MOD_BITS-1:0] m,
  input  logic                         in_valid,
  input  meu_pkg::ap_t                 in_ap,
  output logic                         out_valid,
  output meu_pkg::ap_t                 out_ap
);

  // stage 1: full-width products
  logic                          v1_r;
  logic [meu_pkg::PROD_BITS-1:0] pa_r;
  logic [meu_pkg::PROD_BITS-1:0] pp_r;
  logic [meu_pkg::MOD_BITS-1:0]  acc1_r;

  // stage 2: high part of the reduction
  logic                          v2_r;
  logic [meu_pkg::MOD_BITS-1:0]  ra2_r;
  logic [meu_pkg::MOD_BITS-1:0]  rp2_r;
  logic [meu_pkg::LO_STEPS-1:0]  la2_r;
  logic [meu_pkg::LO_STEPS-1:0]  lp2_r;
  logic [meu_pkg::MOD_BITS-1:0]  acc2_r;

  // stage 3: low part and bit select
  logic                          v3_r;
  meu_pkg::ap_t                  ap3_r;

  logic [meu_pkg::PROD_BITS-1:0] pa_nxt;
  logic [meu_pkg::PROD_BITS-1:0] pp_nxt;
  logic [meu_pkg::MOD_BITS-1:0]  ra2_nxt;
  logic [meu_pkg::MOD_BITS-1:0]  rp2_nxt;
  logic [meu_pkg::MOD_BITS-1:0]  ra3;
  logic [meu_pkg::MOD_BITS-1:0]  rp3;
  meu_pkg::ap_t                  ap3_nxt;

  assign pa_nxt = meu_pkg::PROD_BITS'(in_ap.acc) * meu_pkg::PROD_BITS'(in_ap.pw);
  assign pp_nxt = meu_pkg::PROD_BITS'(in_ap.pw) * meu_pkg::PROD_BITS'(in_ap.pw);

  // high half of a product of two residues is already below m
  always_comb begin
    ra2_nxt = pa_r[meu_pkg::PROD_BITS-1:meu_pkg::MOD_BITS];
    rp2_nxt = pp_r[meu_pkg::PROD_BITS-1:meu_pkg::MOD_BITS];
    for (int k = 0; k < meu_pkg::HI_STEPS; k++) begin
      ra2_nxt = meu_pkg::rem_step(ra2_nxt, pa_r[meu_pkg::MOD_BITS-1-k], m);
      rp2_nxt = meu_pkg::rem_step(rp2_nxt, pp_r[meu_pkg::MOD_BITS-1-k], m);
    end
  end

  always_comb begin
    ra3 = ra2_r;
    rp3 = rp2_r;
    for (int k = 0; k < meu_pkg::LO_STEPS; k++) begin
      ra3 = meu_pkg::rem_step(ra3, la2_r[meu_pkg::LO_STEPS-1-k], m);
      rp3 = meu_pkg::rem_step(rp3, lp2_r[meu_pkg::LO_STEPS-1-k], m);
    end
    ap3_nxt.acc = ebit ? ra3 : acc2_r;
    ap3_nxt.pw  = rp3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= pa_nxt;
      pp_r   <= pp_nxt;
      acc1_r <= in_ap.acc;
      ra2_r  <= ra2_nxt;
      rp2_r  <= rp2_nxt;
      la2_r  <= pa_r[meu_pkg::LO_STEPS-1:0];
      lp2_r  <= pp_r[meu_pkg::LO_STEPS-1:0];
      acc2_r <= acc1_r;
      ap3_r  <= ap3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_ap    = ap3_r;

endmodule

// ===== hw/rtl/modular_exponentiation_unit.sv =====
// Channel   Dir  Ports                          Contents (low bit up)
// in_       in   in_tvalid/in_tready/in_tdata   base_value[31:0]
// out_      out  out_tvalid/out_tready/out_tdata result_value[15:0]
// cfg_      in   cfg_wr_en/cfg_addr/cfg_wdata   0: exponent, 1: modulus
//
// One transaction per cycle while the pipeline is not held: 4 base reduction stages,
// 3 stages per exponent bit (multiply, two reduction halves) for 32 bits, output.
// Synchronous active-low reset clears valid bits and loads exponent 7, modulus 16459.
// A two-entry output (register plus skid) lets input flow while a result waits;
// when both are full the whole pipeline holds.
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [meu_pkg::IN_DATA_BITS-1:0]  in_tdata,   // base_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [meu_pkg::OUT_DATA_BITS-1:0] out_tdata,  // result_value
  input  logic                              cfg_wr_en,
  input  logic [meu_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [meu_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  logic [meu_pkg::EXP_BITS-1:0] exponent_r;
  logic [meu_pkg::MOD_BITS-1:0] modulus_r;

  logic                         en;
  logic                         base_v;
  logic [meu_pkg::MOD_BITS-1:0] base_rem;
  logic [meu_pkg::EXP_BITS:0]   chain_v;
  meu_pkg::ap_t                 chain_ap [meu_pkg::EXP_BITS+1];

  logic                         out_v_r;
  logic [meu_pkg::RES_BITS-1:0] out_d_r;
  logic                         skid_v_r;
  logic [meu_pkg::RES_BITS-1:0] skid_d_r;
  logic                         out_v_nxt;
  logic [meu_pkg::RES_BITS-1:0] out_d_nxt;
  logic                         skid_v_nxt;
  logic [meu_pkg::RES_BITS-1:0] skid_d_nxt;
  logic                         pipe_v;
  logic [meu_pkg::RES_BITS-1:0] pipe_res;
  logic                         take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= meu_pkg::EXP_RESET;
      modulus_r  <= meu_pkg::MOD_RESET;
    end else if (cfg_wr_en) begin
      case (meu_pkg::cfg_idx_t'(cfg_addr))
        meu_pkg::CFG_EXPONENT: exponent_r <= cfg_wdata[meu_pkg::EXP_BITS-1:0];
        meu_pkg::CFG_MODULUS:  modulus_r  <= cfg_wdata[meu_pkg::MOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !skid_v_r;
  assign in_tready = en;

  meu_base_reduce u_base (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .m         (modulus_r),
    .in_valid  (in_tvalid),
    .in_base   (in_tdata[meu_pkg::BASE_BITS-1:0]),
    .out_valid (base_v),
    .out_rem   (base_rem)
  );

  assign chain_v[0]      = base_v;
  assign chain_ap[0].acc = meu_pkg::MOD_BITS'(1);
  assign chain_ap[0].pw  = base_rem;

  for (genvar i = 0; i < meu_pkg::EXP_BITS; i++) begin : g_bit
    meu_exp_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .ebit      (exponent_r[i]),
      .m         (modulus_r),
      .in_valid  (chain_v[i]),
      .in_ap     (chain_ap[i]),
      .out_valid (chain_v[i+1]),
      .out_ap    (chain_ap[i+1])
    );
  end

  // modulus below two gives zero
  assign pipe_v   = chain_v[meu_pkg::EXP_BITS];
  assign pipe_res = (modulus_r < meu_pkg::MOD_BITS'(2)) ? '0 :
                    chain_ap[meu_pkg::EXP_BITS].acc;
  assign take     = out_v_r && out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!out_v_r || take) begin
      out_v_nxt = pipe_v;
      out_d_nxt = pipe_res;
    end else if (pipe_v) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = pipe_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = meu_pkg::OUT_DATA_BITS'(out_d_r);

  `MEU_ASSERT(a_skid_implies_out, !skid_v_r || out_v_r)
  `MEU_ASSERT_NEXT(a_skid_drains, skid_v_r && out_tready, out_v_r && !skid_v_r)
  `MEU_ASSERT_NEXT(a_hold_last, skid_v_r && !out_tready && pipe_v, pipe_v && skid_v_r)

endmodule
